/* sv/dual_color_blob_area_centroid_top_defines.svh */
// Assertion macros used by the blob centroid RTL in dcbac_back.
// Stand-alone header; the macros expect signals named clock and reset in scope.
`ifndef DUAL_COLOR_BLOB_AREA_CENTROID_TOP_DEFINES_SVH
`define DUAL_COLOR_BLOB_AREA_CENTROID_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCBAC_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dcbac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DCBAC_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dcbac assertion failed");

`endif

/* sv/dcbac_pkg.sv */
// Shared types, constants and helper functions of the blob centroid block.
// No dependencies; every module file imports this package.
package dcbac_pkg;

   localparam int ColorW     = 8;
   localparam int CoordW     = 11;
   localparam int WidthRegW  = 12;
   localparam int CountW     = 23;
   localparam int SumW       = 34;
   localparam int RangeW     = 24;
   localparam int CsrIdxW    = 3;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam int NumQuo     = 4;
   localparam int PhaseW     = 2;
   localparam int StepW      = 4;
   localparam int ReqDataW   = 48;
   localparam int RspDataW   = 96;
   localparam int RspUserW   = 2;

   localparam logic [CountW-1:0]    CountMax        = '1;
   localparam logic [RangeW-1:0]    FirstLowReset   = 24'hE9E9E9;
   localparam logic [RangeW-1:0]    FirstHighReset  = 24'hFFFFFF;
   localparam logic [RangeW-1:0]    SecondLowReset  = 24'h0000AB;
   localparam logic [RangeW-1:0]    SecondHighReset = 24'h6EFFFF;
   localparam logic                 MirrorReset     = 1'b1;
   localparam logic [WidthRegW-1:0] WidthReset      = 12'd640;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FIRST_LOW   = 3'd0,
      CSR_FIRST_HIGH  = 3'd1,
      CSR_SECOND_LOW  = 3'd2,
      CSR_SECOND_HIGH = 3'd3,
      CSR_MIRROR      = 3'd4,
      CSR_WIDTH       = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic              hit_first;
      logic              hit_second;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic              last;
   } pix_type;

   typedef struct packed {
      logic              start;
      logic [SumW-1:0]   dividend;
      logic [CountW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CoordW-1:0] quotient;
   } div_rsp_type;

   function automatic logic chan_in(input logic [ColorW-1:0] v,
                                    input logic [ColorW-1:0] lo,
                                    input logic [ColorW-1:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic in_range(input logic [ColorW-1:0] r,
                                     input logic [ColorW-1:0] g,
                                     input logic [ColorW-1:0] b,
                                     input logic [RangeW-1:0] lo,
                                     input logic [RangeW-1:0] hi);
      return chan_in(r, lo[23:16], hi[23:16]) && chan_in(g, lo[15:8], hi[15:8]) &&
             chan_in(b, lo[7:0], hi[7:0]);
   endfunction

endpackage

/* sv/dcbac_front.sv */
// Front end: configuration registers, pixel range tests and column mirroring.
// Depends on dcbac_pkg; feeds classified pixels into dcbac_queue.
module dcbac_front import dcbac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // red, green, blue, column, row from bit 0 up, zero padded
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [RangeW-1:0]   csr_data,
   output logic                push_valid,
   output pix_type             push_data,
   input  logic                push_ready
);

   logic [RangeW-1:0]    first_low_ff, first_low_in;
   logic [RangeW-1:0]    first_high_ff, first_high_in;
   logic [RangeW-1:0]    second_low_ff, second_low_in;
   logic [RangeW-1:0]    second_high_ff, second_high_in;
   logic                 mirror_ff, mirror_in;
   logic [WidthRegW-1:0] width_ff, width_in;

   logic [ColorW-1:0]    red, green, blue;
   logic [CoordW-1:0]    column, row;
   logic [WidthRegW-1:0] mirrored;

   assign csr_ready = 1'b1;

   always_comb begin
      first_low_in   = first_low_ff;
      first_high_in  = first_high_ff;
      second_low_in  = second_low_ff;
      second_high_in = second_high_ff;
      mirror_in      = mirror_ff;
      width_in       = width_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_FIRST_LOW:   first_low_in   = csr_data;
            CSR_FIRST_HIGH:  first_high_in  = csr_data;
            CSR_SECOND_LOW:  second_low_in  = csr_data;
            CSR_SECOND_HIGH: second_high_in = csr_data;
            CSR_MIRROR:      mirror_in      = csr_data[0];
            CSR_WIDTH:       width_in       = csr_data[WidthRegW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_low_ff   <= FirstLowReset;
         first_high_ff  <= FirstHighReset;
         second_low_ff  <= SecondLowReset;
         second_high_ff <= SecondHighReset;
         mirror_ff      <= MirrorReset;
         width_ff       <= WidthReset;
      end else begin
         first_low_ff   <= first_low_in;
         first_high_ff  <= first_high_in;
         second_low_ff  <= second_low_in;
         second_high_ff <= second_high_in;
         mirror_ff      <= mirror_in;
         width_ff       <= width_in;
      end
   end

   assign red    = req_tdata[7:0];
   assign green  = req_tdata[15:8];
   assign blue   = req_tdata[23:16];
   assign column = req_tdata[34:24];
   assign row    = req_tdata[45:35];

   // The mirrored column wraps at twelve bits and keeps its low eleven.
   assign mirrored = width_ff - WidthRegW'(1) - WidthRegW'(column);

   always_comb begin
      push_data.hit_first  = in_range(red, green, blue, first_low_ff, first_high_ff);
      push_data.hit_second = in_range(red, green, blue, second_low_ff, second_high_ff);
      push_data.x          = mirror_ff ? mirrored[CoordW-1:0] : column;
      push_data.y          = row;
      push_data.last       = req_tlast;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

/* sv/dcbac_queue.sv */
// Short first-in first-out queue of classified pixels between front and back.
// Depends on dcbac_pkg for the entry type and depth.
module dcbac_queue import dcbac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  pix_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output pix_type out_data
);

   pix_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]   fill_ff, fill_in;
   logic                 push, pop;

   assign in_ready  = fill_ff != (QueuePtrW+1)'(QueueDepth);
   assign out_valid = fill_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QueuePtrW+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QueuePtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* sv/dcbac_div.sv */
// Restoring divider producing an eleven-bit quotient, one bit per cycle.
// Depends on dcbac_pkg; shared by the four centroid divisions in dcbac_back.
module dcbac_div import dcbac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [SumW-1:0]   rem_ff, rem_in;
   logic [SumW-1:0]   dvs_ff, dvs_in;
   logic [CoordW-1:0] quo_ff, quo_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              ge;

   assign ge = rem_ff >= dvs_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dvs_in  = SumW'({div_req.divisor, (CoordW-1)'(0)});
         quo_in  = '0;
         step_in = StepW'(CoordW - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[CoordW-2:0], ge};
         dvs_in = dvs_ff >> 1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - StepW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* sv/dcbac_back.sv */
// Back end: per-mask moment accumulators, frame-end snapshot, division sequencer
// and result register. Depends on dcbac_pkg and the assertion macros; drives dcbac_div through its ports.
`include "dual_color_blob_area_centroid_top_defines.svh"

module dcbac_back import dcbac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  pix_type             pop_data,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // area_first, area_second, centre_first_x, centre_first_y,
   // centre_second_x, centre_second_y from bit 0 up, zero padded
   output logic [RspDataW-1:0] rsp_tdata,
   // first_found, second_found from bit 0 up
   output logic [RspUserW-1:0] rsp_tuser
);

   typedef enum logic [1:0] {D_IDLE, D_START, D_WAIT, D_HOLD} dstate_type;

   logic [CountW-1:0] cnt_ff [2];
   logic [CountW-1:0] cnt_in [2];
   logic [CountW-1:0] cnt_new [2];
   logic [SumW-1:0]   sx_ff [2];
   logic [SumW-1:0]   sx_in [2];
   logic [SumW-1:0]   sx_new [2];
   logic [SumW-1:0]   sy_ff [2];
   logic [SumW-1:0]   sy_in [2];
   logic [SumW-1:0]   sy_new [2];
   logic              hit [2];

   logic [CountW-1:0] cnt_snap_ff [2];
   logic [CountW-1:0] cnt_snap_in [2];
   logic [SumW-1:0]   sum_snap_ff [NumQuo];
   logic [SumW-1:0]   sum_snap_in [NumQuo];
   logic [CoordW-1:0] quo_ff [NumQuo];
   logic [CoordW-1:0] quo_in [NumQuo];

   dstate_type          state_ff, state_in;
   logic [PhaseW-1:0]   phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic [RspUserW-1:0] rsp_user_ff, rsp_user_in;

   logic              take;
   logic              take_last;
   logic              found_first, found_second;
   logic [CoordW-1:0] cfx, cfy, csx, csy;

   assign pop_ready = !pop_data.last || (state_ff == D_IDLE);
   assign take      = pop_valid && pop_ready;
   assign take_last = take && pop_data.last;
   assign hit[0]    = pop_data.hit_first;
   assign hit[1]    = pop_data.hit_second;

   always_comb begin
      for (int m = 0; m < 2; m++) begin
         cnt_new[m] = cnt_ff[m];
         sx_new[m]  = sx_ff[m];
         sy_new[m]  = sy_ff[m];
         if (hit[m] && (cnt_ff[m] != CountMax)) begin
            cnt_new[m] = cnt_ff[m] + CountW'(1);
            sx_new[m]  = sx_ff[m] + SumW'(pop_data.x);
            sy_new[m]  = sy_ff[m] + SumW'(pop_data.y);
         end
         cnt_in[m]      = cnt_ff[m];
         sx_in[m]       = sx_ff[m];
         sy_in[m]       = sy_ff[m];
         cnt_snap_in[m] = cnt_snap_ff[m];
         if (take_last) begin
            cnt_in[m]      = '0;
            sx_in[m]       = '0;
            sy_in[m]       = '0;
            cnt_snap_in[m] = cnt_new[m];
         end else if (take) begin
            cnt_in[m] = cnt_new[m];
            sx_in[m]  = sx_new[m];
            sy_in[m]  = sy_new[m];
         end
      end
      for (int p = 0; p < NumQuo; p++) begin
         sum_snap_in[p] = sum_snap_ff[p];
      end
      if (take_last) begin
         sum_snap_in[0] = sx_new[0];
         sum_snap_in[1] = sy_new[0];
         sum_snap_in[2] = sx_new[1];
         sum_snap_in[3] = sy_new[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < 2; m++) begin
            cnt_ff[m] <= '0;
            sx_ff[m]  <= '0;
            sy_ff[m]  <= '0;
         end
      end else begin
         for (int m = 0; m < 2; m++) begin
            cnt_ff[m] <= cnt_in[m];
            sx_ff[m]  <= sx_in[m];
            sy_ff[m]  <= sy_in[m];
         end
      end
      for (int m = 0; m < 2; m++) begin
         cnt_snap_ff[m] <= cnt_snap_in[m];
      end
      for (int p = 0; p < NumQuo; p++) begin
         sum_snap_ff[p] <= sum_snap_in[p];
      end
   end

   assign div_req.start    = state_ff == D_START;
   assign div_req.dividend = sum_snap_ff[phase_ff];
   assign div_req.divisor  = cnt_snap_ff[phase_ff[PhaseW-1]];

   assign found_first  = cnt_snap_ff[0] != '0;
   assign found_second = cnt_snap_ff[1] != '0;
   assign cfx = found_first ? quo_ff[0] : '0;
   assign cfy = found_first ? quo_ff[1] : '0;
   assign csx = found_second ? quo_ff[2] : '0;
   assign csy = found_second ? quo_ff[3] : '0;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      for (int p = 0; p < NumQuo; p++) begin
         quo_in[p] = quo_ff[p];
      end
      case (state_ff)
         D_IDLE: begin
            if (take_last) begin
               phase_in = '0;
               state_in = D_START;
            end
         end
         D_START: begin
            state_in = D_WAIT;
         end
         D_WAIT: begin
            if (div_rsp.done) begin
               quo_in[phase_ff] = div_rsp.quotient;
               if (phase_ff == PhaseW'(NumQuo - 1)) begin
                  state_in = D_HOLD;
               end else begin
                  phase_in = phase_ff + PhaseW'(1);
                  state_in = D_START;
               end
            end
         end
         D_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RspDataW'({csy, csx, cfy, cfx, cnt_snap_ff[1], cnt_snap_ff[0]});
               rsp_user_in  = {found_second, found_first};
               state_in     = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= D_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      for (int p = 0; p < NumQuo; p++) begin
         quo_ff[p] <= quo_in[p];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `DCBAC_ASSERT_IMP(a_last_only_when_idle, take_last, state_ff == D_IDLE)
   `DCBAC_ASSERT_IMP(a_done_while_waiting, div_rsp.done, state_ff == D_WAIT)
   `DCBAC_ASSERT_IMP(a_found_matches_area, rsp_valid_ff, (rsp_data_ff[22:0] != '0) == rsp_user_ff[0])
   `DCBAC_ASSERT_IMP(a_empty_mask_zero_centre, rsp_valid_ff && !rsp_user_ff[1], rsp_data_ff[89:68] == '0)

endmodule

/* sv/dual_color_blob_area_centroid_top.sv */
// Pixels enter at one per cycle while the queue has room; each is tested against both
// color ranges as it is accepted and only counted and summed afterward. A transfer
// marked tlast closes the frame: its pixel is counted, the counts and sums are copied
// aside, the accumulators clear, and one shared restoring divider forms the four
// centroids at one quotient bit per cycle, after which one result transfer carries both
// areas, both centroids and the found flags. Pixels of the next frame keep streaming
// during the division through a four-entry queue; a second frame end, and the pixels
// behind it, wait until the previous result has been moved into the result register.
module dual_color_blob_area_centroid_top import dcbac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // red, green, blue, column, row from bit 0 up, zero padded
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // area_first, area_second, centre_first_x, centre_first_y,
   // centre_second_x, centre_second_y from bit 0 up, zero padded
   output logic [RspDataW-1:0] rsp_tdata,
   // first_found, second_found from bit 0 up
   output logic [RspUserW-1:0] rsp_tuser,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [RangeW-1:0]   csr_data
);

   logic        push_valid, push_ready;
   pix_type     push_data;
   logic        pop_valid, pop_ready;
   pix_type     pop_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   dcbac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   dcbac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   dcbac_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dcbac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
